@@ rtl/core/sorted_table_upper_bound_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted table upper bound: assertion macros
// Concurrent check wrappers used by the asserting RTL file.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_UPPER_BOUND_DEFINES_SVH
`define SORTED_TABLE_UPPER_BOUND_DEFINES_SVH

`ifndef ASSERT_OFF
// check outside reset
`define STUB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on every edge, reset included
`define STUB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STUB_ASSERT(name, prop, msg)
`define STUB_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ rtl/core/stub_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table upper bound: package
// Sizes, command codes and the item carried down the search pipeline.
// ----------------------------------------------------------------------------
package stub_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned NSTG   = ADDR_W + 1;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned CNT_W  = 11;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [SLOT_W-1:0]        slot;
    logic signed [KEY_W-1:0]  key;
    logic                     chk;
    logic                     pend;
    logic                     done;
    logic [ADDR_W-1:0]        lo;
    logic [ADDR_W-1:0]        hi;
    logic [ADDR_W-1:0]        mid;
    logic [CNT_W-1:0]         pos;
  } stub_item_t;

endpackage

@@ rtl/core/stub_stage.sv @@
// ----------------------------------------------------------------------------
// Sorted table upper bound: search stage
// One pipeline stage with its own copy of the key table. A write item updates
// the copy as it enters; a query reads its probe point as it enters, then
// resolves the compare and picks the next probe point.
// ----------------------------------------------------------------------------
module stub_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_vld_i,
  input  stub_pkg::stub_item_t in_item_i,
  output logic                out_vld_o,
  output stub_pkg::stub_item_t out_item_o
);
  import stub_pkg::*;

  logic [KEY_W-1:0]  mem [DEPTH];
  logic [KEY_W-1:0]  rdata_q;
  logic              vld_q;
  stub_item_t        item_q;
  stub_item_t        res;
  logic              lt;
  logic              slot_ok;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W:0]   sum;

  assign slot_ok = (CNT_W'(in_item_i.slot) < CNT_W'(DEPTH));
  assign waddr   = ADDR_W'(in_item_i.slot);

  always_ff @(posedge clk_i) begin
    if (en_i && in_vld_i) begin
      if (in_item_i.cmd == CMD_WRITE) begin
        if (slot_ok) begin
          mem[waddr] <= in_item_i.key;
        end
      end else if (in_item_i.pend) begin
        rdata_q <= mem[in_item_i.mid];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= in_item_i;
    end
  end

  always_comb begin
    res = item_q;
    lt  = ($signed(item_q.key) < $signed(rdata_q));
    sum = '0;
    if (vld_q && item_q.cmd == CMD_QUERY && item_q.pend) begin
      res.pend = 1'b0;
      if (item_q.chk) begin
        res.chk = 1'b0;
        if (!lt) begin
          res.done = 1'b1;
        end
      end else if (lt) begin
        res.hi = item_q.mid;
      end else begin
        res.lo = item_q.mid + 1'b1;
      end
      if (!res.done && res.lo == res.hi) begin
        res.done = 1'b1;
        res.pos  = CNT_W'(res.lo);
      end
    end
    if (res.cmd == CMD_QUERY && !res.done) begin
      sum      = {1'b0, res.lo} + {1'b0, res.hi};
      res.mid  = sum[ADDR_W:1];
      res.pend = 1'b1;
    end
  end

  assign out_vld_o  = vld_q;
  assign out_item_o = res;

endmodule

@@ rtl/core/sorted_table_upper_bound.sv @@
// ----------------------------------------------------------------------------
// Sorted table upper bound: top level
// Upper bound of a signed 64-bit probe over a key table loaded by write
// items, found by a binary search pipelined one probe per stage.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       in_valid_i/in_stall_o   cmd, slot, entry_value, probe_value
//  out      source     out_valid_o/out_stall_i position
//  cfg      sink       cfg_valid_i/cfg_ready_o count
//
//  One item per cycle unless the output stalls; a query does one table read
//  per stage: the last-key check plus ten halving steps, then a result register.
//  Each stage keeps its own table copy, updated as write items pass through.
//  A stalled output holds every stage; write items give no result.
//  Reset clears valid bits and count only; table contents are undefined.
// ----------------------------------------------------------------------------
`include "sorted_table_upper_bound_defines.svh"

module sorted_table_upper_bound (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [stub_pkg::CNT_W-1:0]   cfg_count_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [stub_pkg::SLOT_W-1:0]  slot_i,
  input  logic signed [stub_pkg::KEY_W-1:0] entry_value_i,
  input  logic signed [stub_pkg::KEY_W-1:0] probe_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [stub_pkg::CNT_W-1:0]   position_o
);
  import stub_pkg::*;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_m1;
  logic             en;
  logic             out_vld_q;
  logic [CNT_W-1:0] position_q;
  logic             last_qry;
  logic             last_done;
  stub_item_t       front;
  logic             chain_vld  [NSTG+1];
  stub_item_t       chain_item [NSTG+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_count_i;
    end
  end

  assign n_eff = (count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : count_q;
  assign n_m1  = n_eff - 1'b1;

  always_comb begin
    front      = '0;
    front.cmd  = cmd_e'(cmd_i);
    front.slot = slot_i;
    front.key  = (front.cmd == CMD_WRITE) ? entry_value_i : probe_value_i;
    front.done = 1'b1;
    if (front.cmd == CMD_QUERY && n_eff != '0) begin
      front.done = 1'b0;
      front.chk  = 1'b1;
      front.pend = 1'b1;
      front.hi   = ADDR_W'(n_m1);
      front.mid  = ADDR_W'(n_m1);
      front.pos  = n_eff;
    end
  end

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  assign chain_vld[0]  = in_valid_i;
  assign chain_item[0] = front;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    stub_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .in_vld_i   (chain_vld[s]),
      .in_item_i  (chain_item[s]),
      .out_vld_o  (chain_vld[s+1]),
      .out_item_o (chain_item[s+1])
    );
  end

  assign last_qry  = chain_vld[NSTG] && (chain_item[NSTG].cmd == CMD_QUERY);
  assign last_done = chain_item[NSTG].done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= last_qry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      position_q <= chain_item[NSTG].pos;
    end
  end

  assign out_valid_o = out_vld_q;
  assign position_o  = position_q;

  `STUB_ASSERT(a_search_done, last_qry |-> last_done, "query left the last stage unresolved")
  `STUB_ASSERT(a_pos_range, out_vld_q |-> (position_q <= n_eff), "position beyond the entries in use")
  `STUB_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> !out_vld_q, "result valid after a reset edge")

endmodule
